>>> src/urlpd_pkg.sv
package urlpd_pkg;

  localparam int unsigned LEN_W = 16;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd4096;

  localparam logic [7:0] CHR_PCT   = 8'h25;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0]       data;
    logic             byte_valid;
    logic             url_done;
    logic             decode_error;
    logic [LEN_W-1:0] length;
  } result_t;

endpackage

>>> src/urlpd_core.sv
module urlpd_core import urlpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LEN_W-1:0] max_len,
  input  logic             item_valid,
  input  item_t            item,
  output logic             take,
  output logic             out_valid,
  input  logic             out_stall,
  output result_t          out_res
);

  typedef enum logic [1:0] {
    PH_COPY,
    PH_HI,
    PH_LO,
    PH_DISCARD
  } phase_t;

  phase_t           ph_r, ph_nxt;
  logic [3:0]       hi_r, hi_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r;
  result_t          out_res_r;

  logic             has_res;
  result_t          res;
  logic             hex_ok;
  logic [3:0]       hex_nib;
  logic [LEN_W-1:0] cnt_inc;
  logic             emit_ok;

  // Digits map to their low nibble; letters A-F and a-f add nine to it.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  assign {hex_ok, hex_nib} = hex_decode(item.data);
  assign cnt_inc = cnt_r + 1'b1;

  always_comb begin
    has_res = 1'b0;
    res     = '0;
    res.length = cnt_r;
    ph_nxt  = ph_r;
    hi_nxt  = hi_r;
    cnt_nxt = cnt_r;
    case (ph_r)
      PH_COPY: begin
        if (cnt_r >= max_len) begin
          has_res = item.last;
          res.url_done = 1'b1;
        end else if (item.data == CHR_PCT) begin
          if (item.last) begin
            has_res = 1'b1;
            res.url_done = 1'b1;
            res.decode_error = 1'b1;
          end else begin
            ph_nxt = PH_HI;
          end
        end else begin
          has_res = 1'b1;
          cnt_nxt = cnt_inc;
          res.data = (item.data == CHR_PLUS) ? CHR_SPACE : item.data;
          res.byte_valid = 1'b1;
          res.url_done = item.last;
          res.length = cnt_inc;
        end
      end
      PH_HI: begin
        if (!hex_ok || item.last) begin
          has_res = 1'b1;
          res.url_done = item.last;
          res.decode_error = 1'b1;
          ph_nxt = PH_DISCARD;
        end else begin
          hi_nxt = hex_nib;
          ph_nxt = PH_LO;
        end
      end
      PH_LO: begin
        has_res = 1'b1;
        res.url_done = item.last;
        if (!hex_ok) begin
          res.decode_error = 1'b1;
          ph_nxt = PH_DISCARD;
        end else begin
          cnt_nxt = cnt_inc;
          res.data = {hi_r, hex_nib};
          res.byte_valid = 1'b1;
          res.length = cnt_inc;
          ph_nxt = PH_COPY;
          hi_nxt = 4'd0;
        end
      end
      default: begin
        has_res = item.last;
        res.url_done = 1'b1;
        res.decode_error = 1'b1;
      end
    endcase
    // The last byte of a URL always returns the state to its start.
    if (item.last) begin
      ph_nxt  = PH_COPY;
      hi_nxt  = 4'd0;
      cnt_nxt = '0;
    end
  end

  assign emit_ok = !out_valid_r || !out_stall;
  assign take    = item_valid && (emit_ok || !has_res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_COPY;
      hi_r        <= 4'd0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_res_r   <= '0;
    end else begin
      if (take) begin
        ph_r  <= ph_nxt;
        hi_r  <= hi_nxt;
        cnt_r <= cnt_nxt;
      end
      if (emit_ok) begin
        out_valid_r <= take && has_res;
        if (take && has_res) begin
          out_res_r <= res;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_no_valid_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.byte_valid && out_res_r.decode_error))
    else $error("result carries both a byte and an error");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.last) |=> (ph_r == PH_COPY && cnt_r == '0 && hi_r == 4'd0))
    else $error("state not cleared after the last byte of a URL");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.byte_valid) |-> (out_res_r.data == 8'd0))
    else $error("result without a byte has a nonzero byte field");

  a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (take && ph_r == PH_DISCARD && !item.last) |=> (ph_r == PH_DISCARD))
    else $error("discard phase left before the end of the URL");

endmodule

>>> src/url_percent_decoder_top.sv
// Path: a beat passes through the input register (s1_item_r) and then the
// core's output register (out_res_r); a held output result can stall it between.
// Throughput: one beat per cycle; bytes that give no result never wait
// on the output side, and a held result stalls input only when a new one is due.
// Reset: synchronous, active-low rst_n clears the URL state, both
// pipeline valids, and sets max_len_r to 4096.
module url_percent_decoder_top import urlpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_url_done,
  output logic             out_decode_error,
  output logic [LEN_W-1:0] out_length
);

  logic [LEN_W-1:0] max_len_r;
  logic             s1_valid_r;
  item_t            s1_item_r;
  logic             take;
  result_t          res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= MAX_LEN_RESET;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item_r <= '{data: in_byte, last: in_last};
    end
  end

  // The input register refills whenever its beat moves into the core.
  assign in_stall = s1_valid_r && !take;

  urlpd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_len    (max_len_r),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (res)
  );

  assign out_byte         = res.data;
  assign out_byte_valid   = res.byte_valid;
  assign out_url_done     = res.url_done;
  assign out_decode_error = res.decode_error;
  assign out_length       = res.length;

endmodule
